// ===== hdl/hysteresis_code_debouncer_top_macros.svh =====
// Assertion macros used by the checker file of the debouncer.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef HYSTERESIS_CODE_DEBOUNCER_TOP_MACROS_SVH
`define HYSTERESIS_CODE_DEBOUNCER_TOP_MACROS_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define HCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/hcd_pkg.sv =====
package hcd_pkg;

  // Geometry of one poll.
  localparam int unsigned NUM_CHANNELS  = 5;
  localparam int unsigned SAMPLE_BITS   = 10;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned SETTLE_BITS   = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef logic [NUM_CHANNELS-1:0] code_t;
  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [TIME_BITS-1:0]    stamp_t;
  typedef logic [SETTLE_BITS-1:0]  settle_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_THRESHOLD  = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_SETTLE_TIME    = 2'd2,
    REG_IGNORE_BORDER  = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam sample_t RST_LOW_THRESHOLD  = sample_t'(500);
  localparam sample_t RST_HIGH_THRESHOLD = sample_t'(600);
  localparam settle_t RST_SETTLE_TIME    = settle_t'(200);
  localparam logic    RST_IGNORE_BORDER  = 1'b0;

  // One poll.
  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    stamp_t  now_ms;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic  changed;
    code_t active_code;
    code_t canonical_code;
  } out_item_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    sample_t low_threshold;
    sample_t high_threshold;
    settle_t settle_time_ms;
    logic    ignore_border;
  } cfg_t;

  // Lesser of a code and its bit reversal.
  function automatic code_t mirror_min(code_t code);
    code_t rev;
    rev = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rev[NUM_CHANNELS-1-i] = code[i];
    end
    return (code < rev) ? code : rev;
  endfunction

endpackage

// ===== hdl/hcd_cfg.sv =====
module hcd_cfg
  import hcd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // Register file, written one register per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= RST_LOW_THRESHOLD;
      cfg_q.high_threshold <= RST_HIGH_THRESHOLD;
      cfg_q.settle_time_ms <= RST_SETTLE_TIME;
      cfg_q.ignore_border  <= RST_IGNORE_BORDER;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_SETTLE_TIME:    cfg_q.settle_time_ms <= cfg_data_i[SETTLE_BITS-1:0];
        REG_IGNORE_BORDER:  cfg_q.ignore_border  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/hcd_core.sv =====
module hcd_core
  import hcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  code_t  cand_q, cand_d;
  code_t  stable_q, stable_d;
  code_t  mirror_q, mirror_d;
  stamp_t stamp_q, stamp_d;

  sample_t samples [NUM_CHANNELS];
  logic    cand_moved;
  stamp_t  elapsed;
  logic    accept;
  logic    border;

  assign samples[0] = item_i.sample_0;
  assign samples[1] = item_i.sample_1;
  assign samples[2] = item_i.sample_2;
  assign samples[3] = item_i.sample_3;
  assign samples[4] = item_i.sample_4;

  // Per-channel hysteresis; clearing wins when the thresholds cross.
  always_comb begin
    cand_d = cand_q;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      priority if (samples[i] <= cfg_i.low_threshold) begin
        cand_d[i] = 1'b0;
      end else if (samples[i] >= cfg_i.high_threshold) begin
        cand_d[i] = 1'b1;
      end else begin
        cand_d[i] = cand_q[i];
      end
    end
  end

  // A moved candidate restarts the settle timer at this poll's time.
  assign cand_moved = (cand_d != cand_q);
  assign stamp_d    = cand_moved ? item_i.now_ms : stamp_q;
  assign elapsed    = item_i.now_ms - stamp_d;

  // Acceptance of a settled candidate.
  assign accept   = (cand_d != stable_q) &&
                    (elapsed >= {{(TIME_BITS-SETTLE_BITS){1'b0}}, cfg_i.settle_time_ms});
  assign stable_d = accept ? cand_d : stable_q;
  assign mirror_d = accept ? mirror_min(cand_d) : mirror_q;
  assign border   = (cand_d == '0) || (cand_d == '1);

  assign result_o.changed        = accept && !(cfg_i.ignore_border && border);
  assign result_o.active_code    = stable_d;
  assign result_o.canonical_code = mirror_d;

  // Debouncer state, advanced once per poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= '0;
      stable_q <= '0;
      mirror_q <= '0;
      stamp_q  <= '0;
    end else if (step_i) begin
      cand_q   <= cand_d;
      stable_q <= stable_d;
      mirror_q <= mirror_d;
      stamp_q  <= stamp_d;
    end
  end

endmodule

// ===== hdl/hysteresis_code_debouncer_top.sv =====
// Hysteresis code debouncer. Every poll (five samples and a millisecond time)
// yields exactly one result, in order. A poll is registered on entry, goes
// through the threshold, settle-timer and mirror logic and lands in the
// output register, so one poll per clock is sustained while the output is
// not stalled. The debouncer state is updated in the same cycle the result
// is registered, so the next poll sees it immediately. Configuration writes
// take effect on the next edge and must be made while no poll is in flight.
module hysteresis_code_debouncer_top
  import hcd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t      cfg;
  out_item_t result;
  in_item_t  in_item_q;
  out_item_t out_item_q;
  logic      in_valid_q;
  logic      out_valid_q;
  logic      step;
  logic      in_accept;

  // The input register moves on whenever the output register is free or drains.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  hcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Valid flags of the input and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// ===== hdl/hcd_checker.sv =====
`include "hysteresis_code_debouncer_top_macros.svh"

module hcd_checker
  import hcd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  code_t last_active_q;
  logic  out_accept;
  logic  out_hold;
  code_t mirror_of_active;
  logic  code_moved;
  logic  border_code;
  logic  changed_ok;

  assign out_accept       = out_valid_o && !out_stall_i;
  assign out_hold         = out_valid_o && out_stall_i;
  assign mirror_of_active = mirror_min(out_data_o.active_code);

  // A reported change needs a new code; a new code is reported unless it is a border code.
  assign code_moved  = (out_data_o.active_code != last_active_q);
  assign border_code = (out_data_o.active_code == '0) || (out_data_o.active_code == '1);
  assign changed_ok  = (!out_data_o.changed || code_moved) &&
                       (!code_moved || out_data_o.changed || border_code);

  // Active code of the last delivered transaction; the stable code resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_active_q <= '0;
    end else if (out_accept) begin
      last_active_q <= out_data_o.active_code;
    end
  end

  `HCD_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

  `HCD_ASSERT(a_out_hold, out_hold |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  `HCD_ASSERT(a_no_stall_when_drained, !out_stall_i |-> !in_stall_o, "input stalled, output free")

  `HCD_ASSERT(a_canonical, out_valid_o |-> out_data_o.canonical_code == mirror_of_active, "bad mirror")

  `HCD_ASSERT(a_changed_consistent, out_accept |-> changed_ok, "change flag disagrees with code")

endmodule

bind hysteresis_code_debouncer_top hcd_checker u_hcd_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hcd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned GAP_PERCENT    = 22;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_POLLS    = 275;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

  // One row of the directed table: optional reprogramming, one poll and,
  // where it is obvious, the result typed in by hand.
  typedef struct packed {
    logic      reconf;
    cfg_t      cfg;
    in_item_t  poll;
    logic      pinned;
    out_item_t res;
  } poll_row_t;

  // Hand-typed result that travels with a poll until it is accepted.
  typedef struct packed {
    logic      pinned;
    out_item_t res;
  } pin_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     poll_valid = 1'b0;
  logic                     poll_stall;
  in_item_t                 poll_bus = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  out_item_t                res_bus;
  logic                     cfg_we = 1'b0;
  cfg_reg_e                 cfg_index = REG_LOW_THRESHOLD;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Debouncer state and configuration as the scoreboard sees them.
  cfg_t   cfg_model = '{RST_LOW_THRESHOLD, RST_HIGH_THRESHOLD, RST_SETTLE_TIME,
                        RST_IGNORE_BORDER};
  code_t  cand_code = '0;
  code_t  stable_code = '0;
  code_t  mirror_code = '0;
  stamp_t cand_stamp = '0;

  out_item_t result_q[$];
  pin_t      pin_q[$];
  poll_row_t poll_rows[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        poll_gaps_on = 1'b1;
  bit        res_stalls_on = 1'b1;

  hysteresis_code_debouncer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poll_valid),
    .in_stall_o  (poll_stall),
    .in_data_i   (poll_bus),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Random back-pressure on the result side.
  always @(negedge clk_i) begin
    res_stall <= res_stalls_on && ($urandom_range(99) < GAP_PERCENT);
  end

  // Applies one poll to the debouncer state and returns the result it yields.
  function automatic out_item_t debounce_poll(in_item_t p);
    sample_t   smp[NUM_CHANNELS];
    code_t     next_code;
    code_t     rev;
    stamp_t    held;
    out_item_t r;
    smp[0] = p.sample_0;
    smp[1] = p.sample_1;
    smp[2] = p.sample_2;
    smp[3] = p.sample_3;
    smp[4] = p.sample_4;
    next_code = cand_code;
    // Hysteresis per channel; clearing wins when the thresholds cross.
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (smp[i] <= cfg_model.low_threshold) begin
        next_code[i] = 1'b0;
      end else if (smp[i] >= cfg_model.high_threshold) begin
        next_code[i] = 1'b1;
      end
    end
    if (next_code != cand_code) begin
      cand_code  = next_code;
      cand_stamp = p.now_ms;
    end
    r.changed = 1'b0;
    held = p.now_ms - cand_stamp;
    if (cand_code != stable_code && held >= stamp_t'(cfg_model.settle_time_ms)) begin
      stable_code = cand_code;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rev[NUM_CHANNELS-1-i] = stable_code[i];
      end
      mirror_code = (stable_code < rev) ? stable_code : rev;
      r.changed = !cfg_model.ignore_border ||
                  (stable_code != '0 && stable_code != '1);
    end
    r.active_code    = stable_code;
    r.canonical_code = mirror_code;
    return r;
  endfunction

  // Sample value meant to drive a channel bit to b under the current thresholds,
  // now and then one from the dead band that leaves the bit alone.
  function automatic sample_t level_for(bit b);
    int lo;
    int hi;
    lo = int'(cfg_model.low_threshold);
    hi = int'(cfg_model.high_threshold);
    if (lo + 1 <= hi - 1 && $urandom_range(99) < 20) begin
      return sample_t'($urandom_range(hi - 1, lo + 1));
    end
    if (b) begin
      return sample_t'($urandom_range(SAMPLE_MAX, hi));
    end
    return sample_t'($urandom_range(lo, 0));
  endfunction

  function automatic poll_row_t make_row(logic reconf, cfg_t c, sample_t s0, sample_t s1,
                                         sample_t s2, sample_t s3, sample_t s4, stamp_t t,
                                         logic pinned, logic ch, code_t ac, code_t cc);
    poll_row_t row;
    row.reconf             = reconf;
    row.cfg                = c;
    row.poll.sample_0      = s0;
    row.poll.sample_1      = s1;
    row.poll.sample_2      = s2;
    row.poll.sample_3      = s3;
    row.poll.sample_4      = s4;
    row.poll.now_ms        = t;
    row.pinned             = pinned;
    row.res.changed        = ch;
    row.res.active_code    = ac;
    row.res.canonical_code = cc;
    return row;
  endfunction

  // Scoreboard: checks results, predicts accepted polls, follows register
  // writes and watches for a stuck handshake.
  always @(posedge clk_i) begin
    out_item_t want;
    pin_t      pin;
    out_item_t predicted;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (res_valid && !res_stall) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          error_count++;
          $display("%0t: result with none pending: changed=%0b active=%0d canonical=%0d",
                   $time, res_bus.changed, res_bus.active_code, res_bus.canonical_code);
        end else begin
          want = result_q.pop_front();
          if (res_bus.changed !== want.changed) begin
            error_count++;
            $display("%0t: changed expected %0b, actual %0b",
                     $time, want.changed, res_bus.changed);
          end
          if (res_bus.active_code !== want.active_code) begin
            error_count++;
            $display("%0t: active_code expected %0d, actual %0d",
                     $time, want.active_code, res_bus.active_code);
          end
          if (res_bus.canonical_code !== want.canonical_code) begin
            error_count++;
            $display("%0t: canonical_code expected %0d, actual %0d",
                     $time, want.canonical_code, res_bus.canonical_code);
          end
        end
      end
      if (poll_valid && !poll_stall) begin
        idle_cycles = 0;
        pin = pin_q.pop_front();
        predicted = debounce_poll(poll_bus);
        result_q.push_back(pin.pinned ? pin.res : predicted);
      end
      if (cfg_we) begin
        idle_cycles = 0;
        case (cfg_index)
          REG_LOW_THRESHOLD:  cfg_model.low_threshold  = sample_t'(cfg_data);
          REG_HIGH_THRESHOLD: cfg_model.high_threshold = sample_t'(cfg_data);
          REG_SETTLE_TIME:    cfg_model.settle_time_ms = settle_t'(cfg_data);
          REG_IGNORE_BORDER:  cfg_model.ignore_border  = cfg_data[0];
          default: ;
        endcase
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("hysteresis_code_debouncer_top: mismatch");
        $finish;
      end
    end
  end

  // Offers one poll, with random gaps ahead of it, and holds it until taken.
  task automatic drive_poll(in_item_t p, logic pinned, out_item_t res);
    pin_t pin;
    while (poll_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      poll_valid <= 1'b0;
      @(negedge clk_i);
    end
    pin.pinned = pinned;
    pin.res    = res;
    pin_q.push_back(pin);
    poll_valid <= 1'b1;
    poll_bus   <= p;
    do begin
      @(posedge clk_i);
    end while (poll_stall);
    @(negedge clk_i);
  endtask

  // Waits until every result is in, lets the pipeline drain, then writes
  // all four registers back to back.
  task automatic program_cfg(cfg_t c);
    poll_valid <= 1'b0;
    while (result_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_THRESHOLD;
    cfg_data  <= CFG_DATA_BITS'(c.low_threshold);
    @(negedge clk_i);
    cfg_index <= REG_HIGH_THRESHOLD;
    cfg_data  <= CFG_DATA_BITS'(c.high_threshold);
    @(negedge clk_i);
    cfg_index <= REG_SETTLE_TIME;
    cfg_data  <= CFG_DATA_BITS'(c.settle_time_ms);
    @(negedge clk_i);
    cfg_index <= REG_IGNORE_BORDER;
    cfg_data  <= CFG_DATA_BITS'(c.ignore_border);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    cfg_t     c;
    cfg_t     dflt;
    in_item_t p;
    stamp_t   t;
    code_t    target;
    int       sent;
    int       hold;
    int       step_max;

    dflt = '{RST_LOW_THRESHOLD, RST_HIGH_THRESHOLD, RST_SETTLE_TIME, RST_IGNORE_BORDER};

    // Directed polls. From reset: a code must hold the full settle time, the
    // dead band keeps bits, mirrored codes fold, and the timer wraps.
    poll_rows.push_back(make_row(0, dflt, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 1023, 1023, 1023, 10, 1, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 1023, 1023, 1023, 209, 1, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 1023, 1023, 1023, 210, 1, 1, 31, 31));
    poll_rows.push_back(make_row(0, dflt, 550, 550, 550, 550, 550, 300, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 500, 500, 500, 500, 500, 400, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 0, 0, 0, 0, 0, 600, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 600, 0, 0, 0, 0, 1000, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 600, 0, 0, 0, 0, 1200, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 0, 0, 0, 0, 1023, 1300, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 0, 0, 0, 0, 1023, 1500, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 0, 0, 0, 32'hFFFF_FFA0, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 0, 0, 0, 32'h0000_0068, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, dflt, 1023, 1023, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 3, 3));
    // Zero settle time with border codes suppressed.
    c = '{10'd500, 10'd600, 16'd0, 1'b1};
    poll_rows.push_back(make_row(1, c, 1023, 1023, 1023, 1023, 1023, 5, 1, 0, 31, 31));
    poll_rows.push_back(make_row(0, c, 0, 1023, 1023, 0, 0, 6, 0, 0, 0, 0));
    poll_rows.push_back(make_row(0, c, 0, 0, 0, 0, 0, 7, 1, 0, 0, 0));
    // Crossed thresholds: a sample inside both ranges clears.
    c = '{10'd600, 10'd500, 16'd0, 1'b0};
    poll_rows.push_back(make_row(1, c, 700, 550, 400, 1023, 0, 8, 0, 0, 0, 0));
    // Widest dead band.
    c = '{10'd0, 10'd1023, 16'd0, 1'b0};
    poll_rows.push_back(make_row(1, c, 0, 1, 1022, 1023, 512, 9, 1, 1, 8, 2));
    // Everything clears, longest settle time.
    c = '{10'd1023, 10'd0, 16'd65535, 1'b0};
    poll_rows.push_back(make_row(1, c, 1023, 1023, 1023, 1023, 1023, 100, 1, 0, 8, 2));
    poll_rows.push_back(make_row(0, c, 1023, 1023, 1023, 1023, 1023, 65635, 1, 1, 0, 0));

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (poll_rows[i]) begin
      if (poll_rows[i].reconf) begin
        program_cfg(poll_rows[i].cfg);
      end
      drive_poll(poll_rows[i].poll, poll_rows[i].pinned, poll_rows[i].res);
    end

    // Random phases: each holds target codes for a few polls with time
    // moving on, mixed with short bursts and raw noise.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: c = dflt;
        1: c = '{10'd0, 10'd1023, 16'd0, 1'b1};
        2: c = '{10'd700, 10'd300, 16'd65535, 1'b0};
        default: begin
          c.low_threshold  = sample_t'($urandom_range(700, 0));
          c.high_threshold = sample_t'($urandom_range(SAMPLE_MAX, 300));
          c.settle_time_ms = settle_t'($urandom_range(3000, 0));
          c.ignore_border  = 1'($urandom_range(1, 0));
        end
      endcase
      program_cfg(c);
      // One phase runs without any gaps or stalls.
      poll_gaps_on  = (ph != 4);
      res_stalls_on = (ph != 4);
      step_max = (int'(c.settle_time_ms) / 3) + 2;
      t = (ph == 2) ? stamp_t'(32'hFFFF_0000 + $urandom_range(65535, 0)) : stamp_t'($urandom);
      sent = 0;
      while (sent < PHASE_POLLS) begin
        if ($urandom_range(99) < 10) begin
          p = in_item_t'({$urandom, $urandom, $urandom});
          if ($urandom_range(1, 0)) begin
            p.now_ms = t + stamp_t'($urandom_range(step_max, 0));
          end
          t = p.now_ms;
          drive_poll(p, 1'b0, '0);
          sent++;
        end else begin
          target = ($urandom_range(99) < 15) ? {NUM_CHANNELS{$urandom_range(1, 0) == 1}}
                                              : code_t'($urandom_range(31, 0));
          hold = $urandom_range(10, 1);
          for (int k = 0; k < hold; k++) begin
            p.sample_0 = level_for(target[0]);
            p.sample_1 = level_for(target[1]);
            p.sample_2 = level_for(target[2]);
            p.sample_3 = level_for(target[3]);
            p.sample_4 = level_for(target[4]);
            t = t + stamp_t'($urandom_range(step_max, 0));
            p.now_ms = t;
            drive_poll(p, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    poll_valid <= 1'b0;
    while (result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("hysteresis_code_debouncer_top: match");
    end else begin
      $display("hysteresis_code_debouncer_top: mismatch");
    end
    $finish;
  end

endmodule
